// ===== hdl/pti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg: shared types and constants of the piecewise table interpolator
// Widths of the fixed point datapath, register and command codes, the
// sequencer states and the handshake structs of the serial arithmetic unit.
// ----------------------------------------------------------------------------
package pti_pkg;

	localparam int unsigned DEF_MAX_POINTS = 64;

	localparam int unsigned PT_W   = 32;   // breakpoint and result width
	localparam int unsigned DIFF_W = 33;   // difference of two points
	localparam int unsigned MAG_W  = 97;   // magnitude of a three-factor numerator
	localparam int unsigned DEN_W  = 65;   // magnitude of a two-factor denominator
	localparam int unsigned ACC_W  = 100;  // signed sum of up to three quotients
	localparam int unsigned CNT_W  = 7;    // serial step counter
	localparam int unsigned IDX_W  = 6;    // index field of a load
	localparam int unsigned CFG_AW = 4;    // APB byte address width

	typedef enum logic [1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_METHOD      = 2'd1,
		REG_LEFT_MODE   = 2'd2,
		REG_RIGHT_MODE  = 2'd3
	} reg_idx_t;

	localparam logic [1:0] MODE_CONST  = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_ZERO   = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic METHOD_LINEAR = 1'b0;
	localparam logic METHOD_QUAD   = 1'b1;

	typedef enum logic {
		MD_MUL = 1'b0,
		MD_DIV = 1'b1
	} md_op_t;

	typedef struct packed {
		logic   go;
		md_op_t op;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_CLASSIFY,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_FETCH_RD,
		ST_FETCH_CAP,
		ST_TERM_SET,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_DIV,
		ST_FINISH
	} state_t;

	// signed difference of two breakpoint values, one bit wider
	function automatic logic signed [DIFF_W-1:0] diff33(input logic signed [PT_W-1:0] a,
			input logic signed [PT_W-1:0] b);
		return {a[PT_W-1], a} - {b[PT_W-1], b};
	endfunction

	function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ===== hdl/pti_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_muldiv: serial magnitude multiplier and restoring divider
// Multiply: one bit of the short operand per cycle. Divide: one quotient bit
// per cycle over the full numerator. Result holds while done is high.
// ----------------------------------------------------------------------------
module pti_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pti_pkg::md_req_t              req,
	input  logic [pti_pkg::MAG_W-1:0]     a_mag,
	input  logic [pti_pkg::DEN_W-1:0]     b_mag,
	output pti_pkg::md_rsp_t              rsp,
	output logic [pti_pkg::MAG_W-1:0]     result
);

	logic                           busy_q;
	pti_pkg::md_op_t                op_q;
	logic [pti_pkg::CNT_W-1:0]      cnt_q;
	logic [pti_pkg::MAG_W-1:0]      sh_q;
	logic [pti_pkg::MAG_W-1:0]      acc_q;
	logic [pti_pkg::DEN_W-1:0]      b_q;
	logic [pti_pkg::DEN_W:0]        rem_q;
	logic [pti_pkg::DEN_W:0]        rem_sh;
	logic                           fits;
	logic [pti_pkg::DEN_W:0]        rem_nx;
	logic                           step;

	assign step   = busy_q && (cnt_q != '0);
	assign rem_sh = {rem_q[pti_pkg::DEN_W-1:0], sh_q[pti_pkg::MAG_W-1]};
	assign fits   = rem_sh >= {1'b0, b_q};
	assign rem_nx = fits ? (rem_sh - {1'b0, b_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= pti_pkg::MD_MUL;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
			cnt_q  <= (req.op == pti_pkg::MD_MUL) ? pti_pkg::CNT_W'(pti_pkg::DIFF_W)
				: pti_pkg::CNT_W'(pti_pkg::MAG_W);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			sh_q  <= a_mag;
			b_q   <= b_mag;
			acc_q <= '0;
			rem_q <= '0;
		end else if (step) begin
			if (op_q == pti_pkg::MD_MUL) begin
				if (b_q[0]) begin
					acc_q <= acc_q + sh_q;
				end
				sh_q <= {sh_q[pti_pkg::MAG_W-2:0], 1'b0};
				b_q  <= {1'b0, b_q[pti_pkg::DEN_W-1:1]};
			end else begin
				rem_q <= rem_nx;
				sh_q  <= {sh_q[pti_pkg::MAG_W-2:0], fits};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == '0);
	assign result   = (op_q == pti_pkg::MD_MUL) ? acc_q : sh_q;

endmodule

// ===== hdl/piecewise_table_interpolator.sv =====
`timescale 1ns / 1ps
// Sequence: a load writes the tables; the sequencer stays idle. A query reads the first
//   and last points, scans the segments up to the one holding the query (none when
//   extrapolating), fetches 2 or 3 points and computes its terms (1 linear, 3 quadratic,
//   none for a constant, zero or single-point answer), then waits in the finish state
//   while an earlier result is still unaccepted. Queries are taken one at a time; the
//   serial multiply/divide unit and the single table read port bound the query rate.
// Reset: arst_n clears control and configuration state, not the datapath or the tables.
// ----------------------------------------------------------------------------
// piecewise_table_interpolator: breakpoint table with linear and quadratic
// interpolation and configurable extrapolation, signed fixed point.
// ----------------------------------------------------------------------------
module piecewise_table_interpolator #(
	parameter int unsigned MAX_POINTS = pti_pkg::DEF_MAX_POINTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [103:0]                 s_axis_tdata,  // index[5:0], point_x[37:6],
	                                                    // point_y[69:38], query_x[101:70]
	input  logic                         s_axis_tuser,  // cmd
	input  logic                         s_axis_tlast,  // batch_end
	// result stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,  // interp_value[31:0]
	output logic                         m_axis_tuser,  // saturated
	output logic                         m_axis_tlast,  // last_out
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pti_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned NW = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;

	// payload unpack
	logic [pti_pkg::IDX_W-1:0]        in_index;
	logic signed [pti_pkg::PT_W-1:0]  in_px;
	logic signed [pti_pkg::PT_W-1:0]  in_py;
	logic signed [pti_pkg::PT_W-1:0]  in_qx;

	assign in_index = s_axis_tdata[5:0];
	assign in_px    = s_axis_tdata[37:6];
	assign in_py    = s_axis_tdata[69:38];
	assign in_qx    = s_axis_tdata[101:70];

	// configuration registers
	logic [6:0] pc_q;
	logic       method_q;
	logic [1:0] lmode_q;
	logic [1:0] rmode_q;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 7'd1;
			method_q <= pti_pkg::METHOD_LINEAR;
			lmode_q  <= pti_pkg::MODE_CONST;
			rmode_q  <= pti_pkg::MODE_CONST;
		end else if (cfg_we) begin
			unique case (pti_pkg::reg_idx_t'(paddr[3:2]))
				pti_pkg::REG_POINT_COUNT: pc_q     <= pwdata[6:0];
				pti_pkg::REG_METHOD:      method_q <= pwdata[0];
				pti_pkg::REG_LEFT_MODE:   lmode_q  <= pwdata[1:0];
				pti_pkg::REG_RIGHT_MODE:  rmode_q  <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		unique case (pti_pkg::reg_idx_t'(paddr[3:2]))
			pti_pkg::REG_POINT_COUNT: prdata = {25'd0, pc_q};
			pti_pkg::REG_METHOD:      prdata = {31'd0, method_q};
			pti_pkg::REG_LEFT_MODE:   prdata = {30'd0, lmode_q};
			pti_pkg::REG_RIGHT_MODE:  prdata = {30'd0, rmode_q};
		endcase
	end

	// sequencer state and query registers
	pti_pkg::state_t state_q, state_nx;

	logic signed [pti_pkg::PT_W-1:0]  qx_q;
	logic                             last_q;
	logic [NW-1:0]                    n_q;
	logic signed [pti_pkg::PT_W-1:0]  x0_q, y0_q;
	logic [NW-1:0]                    scan_q;
	logic [NW-1:0]                    base_q;
	logic [1:0]                       fcnt_q;
	logic                             quad_q;
	logic signed [pti_pkg::PT_W-1:0]  p0x_q, p1x_q, p2x_q;
	logic signed [pti_pkg::PT_W-1:0]  p0y_q, p1y_q, p2y_q;
	logic [1:0]                       term_q;
	logic signed [pti_pkg::ACC_W-1:0] acc_q;
	logic                             zdiv_q;
	logic                             neg_q;
	logic [pti_pkg::DIFF_W-1:0]       fc_q, da_q, db_q;
	logic [pti_pkg::MAG_W-1:0]        num_q;

	// table memories, one synchronous read port each
	logic signed [pti_pkg::PT_W-1:0]  x_mem [MAX_POINTS];
	logic signed [pti_pkg::PT_W-1:0]  y_mem [MAX_POINTS];
	logic signed [pti_pkg::PT_W-1:0]  x_rd_q, y_rd_q;
	logic [AW-1:0]                    ra_c;
	logic [AW-1:0]                    wa_c;
	logic                             in_acc;
	logic                             load_we;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign load_we = in_acc && (s_axis_tuser == pti_pkg::CMD_LOAD)
		&& (32'(in_index) < MAX_POINTS);
	assign wa_c    = AW'(in_index);

	always_ff @(posedge clk) begin
		if (load_we) begin
			x_mem[wa_c] <= in_px;
			y_mem[wa_c] <= in_py;
		end
		x_rd_q <= x_mem[ra_c];
		y_rd_q <= y_mem[ra_c];
	end

	// serial arithmetic unit
	pti_pkg::md_req_t             md_req;
	pti_pkg::md_rsp_t             md_rsp;
	logic [pti_pkg::MAG_W-1:0]    md_a;
	logic [pti_pkg::DEN_W-1:0]    md_b;
	logic [pti_pkg::MAG_W-1:0]    md_res;

	pti_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a_mag  (md_a),
		.b_mag  (md_b),
		.rsp    (md_rsp),
		.result (md_res)
	);

	// decisions
	logic [NW-1:0] n_c;
	logic          cls_single, cls_left, cls_right;
	logic          scan_hit;
	logic          quad_sel;
	logic [NW-1:0] k_base;
	logic          fetch_last;
	logic          term_last;

	always_comb begin
		if (pc_q == 7'd0) begin
			n_c = NW'(1);
		end else if (NW'(pc_q) > NW'(MAX_POINTS)) begin
			n_c = NW'(MAX_POINTS);
		end else begin
			n_c = NW'(pc_q);
		end
	end

	assign cls_single = (n_q == NW'(1));
	assign cls_left   = (qx_q <= x0_q);
	assign cls_right  = (qx_q > x_rd_q);
	assign scan_hit   = (qx_q <= x_rd_q) || (scan_q == n_q - NW'(2));
	assign quad_sel   = (method_q == pti_pkg::METHOD_QUAD) && (n_q != NW'(2));
	// the last segment borrows the previous point for the quadratic
	assign k_base     = (quad_sel && !((NW+1)'(scan_q) + (NW+1)'(3) <= (NW+1)'(n_q)))
		? (scan_q - NW'(1)) : scan_q;
	assign fetch_last = (fcnt_q == (quad_q ? 2'd2 : 2'd1));
	assign term_last  = (term_q == (quad_q ? 2'd2 : 2'd0));

	// factors of the current term: num = f1*f2*f3, den = d1*d2
	logic signed [pti_pkg::DIFF_W-1:0] f1_c, f2_c, f3_c, d1_c, d2_c;
	logic signed [pti_pkg::PT_W-1:0]   xi_c, yi_c, xj_c, xl_c;
	logic                              tzero_c, tneg_c;

	always_comb begin
		case (term_q)
			2'd0: begin
				xi_c = p0x_q; yi_c = p0y_q; xj_c = p1x_q; xl_c = p2x_q;
			end
			2'd1: begin
				xi_c = p1x_q; yi_c = p1y_q; xj_c = p0x_q; xl_c = p2x_q;
			end
			default: begin
				xi_c = p2x_q; yi_c = p2y_q; xj_c = p0x_q; xl_c = p1x_q;
			end
		endcase
		if (quad_q) begin
			f1_c = pti_pkg::diff33(qx_q, xj_c);
			f2_c = pti_pkg::diff33(qx_q, xl_c);
			f3_c = {yi_c[pti_pkg::PT_W-1], yi_c};
			d1_c = pti_pkg::diff33(xi_c, xj_c);
			d2_c = pti_pkg::diff33(xi_c, xl_c);
		end else begin
			f1_c = pti_pkg::diff33(p1y_q, p0y_q);
			f2_c = pti_pkg::diff33(qx_q, p0x_q);
			f3_c = pti_pkg::DIFF_W'(1);
			d1_c = pti_pkg::diff33(p1x_q, p0x_q);
			d2_c = pti_pkg::DIFF_W'(1);
		end
		tzero_c = (d1_c == '0) || (d2_c == '0);
		tneg_c  = f1_c[pti_pkg::DIFF_W-1] ^ f2_c[pti_pkg::DIFF_W-1] ^ f3_c[pti_pkg::DIFF_W-1]
			^ d1_c[pti_pkg::DIFF_W-1] ^ d2_c[pti_pkg::DIFF_W-1];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pti_pkg::ST_IDLE: begin
				if (in_acc && (s_axis_tuser == pti_pkg::CMD_QUERY)) begin
					state_nx = pti_pkg::ST_RD_FIRST;
				end
			end
			pti_pkg::ST_RD_FIRST: state_nx = pti_pkg::ST_RD_LAST;
			pti_pkg::ST_RD_LAST:  state_nx = pti_pkg::ST_CLASSIFY;
			pti_pkg::ST_CLASSIFY: begin
				if (cls_single) begin
					state_nx = pti_pkg::ST_FINISH;
				end else if (cls_left) begin
					state_nx = (lmode_q == pti_pkg::MODE_LINEAR) ? pti_pkg::ST_FETCH_RD
						: pti_pkg::ST_FINISH;
				end else if (cls_right) begin
					state_nx = (rmode_q == pti_pkg::MODE_LINEAR) ? pti_pkg::ST_FETCH_RD
						: pti_pkg::ST_FINISH;
				end else begin
					state_nx = pti_pkg::ST_SCAN_RD;
				end
			end
			pti_pkg::ST_SCAN_RD:  state_nx = pti_pkg::ST_SCAN_CMP;
			pti_pkg::ST_SCAN_CMP: begin
				state_nx = scan_hit ? pti_pkg::ST_FETCH_RD : pti_pkg::ST_SCAN_RD;
			end
			pti_pkg::ST_FETCH_RD: state_nx = pti_pkg::ST_FETCH_CAP;
			pti_pkg::ST_FETCH_CAP: begin
				state_nx = fetch_last ? pti_pkg::ST_TERM_SET : pti_pkg::ST_FETCH_RD;
			end
			pti_pkg::ST_TERM_SET: begin
				state_nx = tzero_c ? pti_pkg::ST_FINISH : pti_pkg::ST_MUL_A;
			end
			pti_pkg::ST_MUL_A: if (md_rsp.done) state_nx = pti_pkg::ST_MUL_B;
			pti_pkg::ST_MUL_B: if (md_rsp.done) state_nx = pti_pkg::ST_MUL_D;
			pti_pkg::ST_MUL_D: if (md_rsp.done) state_nx = pti_pkg::ST_DIV;
			pti_pkg::ST_DIV: begin
				if (md_rsp.done) begin
					state_nx = term_last ? pti_pkg::ST_FINISH : pti_pkg::ST_TERM_SET;
				end
			end
			pti_pkg::ST_FINISH: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					state_nx = pti_pkg::ST_IDLE;
				end
			end
			default: state_nx = pti_pkg::ST_IDLE;
		endcase
	end

	// state outputs: ready, table read address, arithmetic requests
	always_comb begin
		s_axis_tready = 1'b0;
		ra_c          = '0;
		md_req.go     = 1'b0;
		md_req.op     = pti_pkg::MD_MUL;
		md_a          = '0;
		md_b          = '0;
		unique case (state_q)
			pti_pkg::ST_IDLE:     s_axis_tready = 1'b1;
			pti_pkg::ST_RD_LAST:  ra_c = AW'(n_q - NW'(1));
			pti_pkg::ST_SCAN_RD:  ra_c = AW'(scan_q + NW'(1));
			pti_pkg::ST_FETCH_RD: ra_c = AW'(base_q + NW'(fcnt_q));
			pti_pkg::ST_TERM_SET: begin
				md_req.go = !tzero_c;
				md_a      = pti_pkg::MAG_W'(pti_pkg::mag33(f1_c));
				md_b      = pti_pkg::DEN_W'(pti_pkg::mag33(f2_c));
			end
			pti_pkg::ST_MUL_A: begin
				md_req.go = md_rsp.done;
				md_a      = md_res;
				md_b      = pti_pkg::DEN_W'(fc_q);
			end
			pti_pkg::ST_MUL_B: begin
				md_req.go = md_rsp.done;
				md_a      = pti_pkg::MAG_W'(da_q);
				md_b      = pti_pkg::DEN_W'(db_q);
			end
			pti_pkg::ST_MUL_D: begin
				md_req.go = md_rsp.done;
				md_req.op = pti_pkg::MD_DIV;
				md_a      = num_q;
				md_b      = md_res[pti_pkg::DEN_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pti_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// datapath registers
	logic [pti_pkg::ACC_W-1:0] q_ext;

	assign q_ext = pti_pkg::ACC_W'(md_res);

	always_ff @(posedge clk) begin
		unique case (state_q)
			pti_pkg::ST_IDLE: begin
				// latch the query and the active point count
				if (in_acc && (s_axis_tuser == pti_pkg::CMD_QUERY)) begin
					qx_q   <= in_qx;
					last_q <= s_axis_tlast;
					n_q    <= n_c;
					zdiv_q <= 1'b0;
				end
			end
			pti_pkg::ST_RD_LAST: begin
				x0_q <= x_rd_q;
				y0_q <= y_rd_q;
			end
			pti_pkg::ST_CLASSIFY: begin
				fcnt_q <= '0;
				quad_q <= 1'b0;
				scan_q <= '0;
				if (cls_single) begin
					acc_q <= pti_pkg::ACC_W'(y0_q);
				end else if (cls_left) begin
					base_q <= '0;
					case (lmode_q)
						pti_pkg::MODE_CONST: acc_q <= pti_pkg::ACC_W'(y0_q);
						default:             acc_q <= '0;
					endcase
				end else if (cls_right) begin
					base_q <= n_q - NW'(2);
					case (rmode_q)
						pti_pkg::MODE_CONST: acc_q <= pti_pkg::ACC_W'(y_rd_q);
						default:             acc_q <= '0;
					endcase
				end
			end
			pti_pkg::ST_SCAN_CMP: begin
				// advance to the next segment or hold the one found
				if (scan_hit) begin
					quad_q <= quad_sel;
					base_q <= k_base;
				end else begin
					scan_q <= scan_q + NW'(1);
				end
			end
			pti_pkg::ST_FETCH_CAP: begin
				case (fcnt_q)
					2'd0: begin
						p0x_q <= x_rd_q; p0y_q <= y_rd_q;
					end
					2'd1: begin
						p1x_q <= x_rd_q; p1y_q <= y_rd_q;
					end
					default: begin
						p2x_q <= x_rd_q; p2y_q <= y_rd_q;
					end
				endcase
				fcnt_q <= fcnt_q + 2'd1;
				if (fetch_last) begin
					term_q <= '0;
					acc_q  <= quad_q ? '0 : pti_pkg::ACC_W'(p0y_q);
				end
			end
			pti_pkg::ST_TERM_SET: begin
				fc_q   <= pti_pkg::mag33(f3_c);
				da_q   <= pti_pkg::mag33(d1_c);
				db_q   <= pti_pkg::mag33(d2_c);
				neg_q  <= tneg_c;
				if (tzero_c) begin
					zdiv_q <= 1'b1;
				end
			end
			pti_pkg::ST_MUL_B: begin
				if (md_rsp.done) begin
					num_q <= md_res;
				end
			end
			pti_pkg::ST_DIV: begin
				// the quotient magnitude truncates toward zero; apply its sign
				if (md_rsp.done) begin
					acc_q  <= neg_q ? (acc_q - q_ext) : (acc_q + q_ext);
					term_q <= term_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// saturate to the 32-bit signed range; a zero denominator gives zero, flagged as saturated
	logic                             in_range;
	logic signed [pti_pkg::PT_W-1:0]  res_c;
	logic                             sat_c;

	assign in_range = (&acc_q[pti_pkg::ACC_W-1:pti_pkg::PT_W-1])
		|| !(|acc_q[pti_pkg::ACC_W-1:pti_pkg::PT_W-1]);

	always_comb begin
		if (zdiv_q) begin
			res_c = '0;
			sat_c = 1'b1;
		end else if (in_range) begin
			res_c = acc_q[pti_pkg::PT_W-1:0];
			sat_c = 1'b0;
		end else begin
			res_c = acc_q[pti_pkg::ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			sat_c = 1'b1;
		end
	end

	// output register: holds a result while the next query proceeds
	logic out_load;

	assign out_load = (state_q == pti_pkg::ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= res_c;
			m_axis_tuser <= sat_c;
			m_axis_tlast <= last_q;
		end
	end

`ifndef SYNTHESIS
	a_md_done_in_arith: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == pti_pkg::ST_MUL_A || state_q == pti_pkg::ST_MUL_B
			|| state_q == pti_pkg::ST_MUL_D || state_q == pti_pkg::ST_DIV))
		else $error("arithmetic unit finished outside an arithmetic state");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == pti_pkg::ST_FINISH)
		else $error("result shown without a finished query");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pti_pkg::ST_SCAN_CMP) |-> ((NW+1)'(scan_q) + (NW+1)'(2) <= (NW+1)'(n_q)))
		else $error("segment scan ran past the last segment");

	a_fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pti_pkg::ST_FETCH_RD)
			|-> ((NW+1)'(base_q) + (NW+1)'(fcnt_q) < (NW+1)'(n_q)))
		else $error("point fetch beyond the active points");
`endif

endmodule
